### src/plts_pkg.sv
// shared types, microcode encodings and control store for the lifo task scheduler
package plts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ID_W        = 10;
    localparam int MIN_W       = 11;
    localparam int DUR_W       = 10;

    localparam int UAW   = 3;
    localparam int USTEPS = 8;

    typedef logic [UAW-1:0] t_upc;

    // datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_NONE  = 3'd0;
    localparam t_op OP_LATCH = 3'd1;
    localparam t_op OP_ACMP  = 3'd2;
    localparam t_op OP_PUSH  = 3'd3;
    localparam t_op OP_FIN   = 3'd4;
    localparam t_op OP_FPOP  = 3'd5;

    // jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_ALWAYS   = 3'd0;
    localparam t_cond C_NO_START = 3'd1;
    localparam t_cond C_FLUSH    = 3'd2;
    localparam t_cond C_EMPTY    = 3'd3;
    localparam t_cond C_FITS     = 3'd4;

    // step addresses
    localparam t_upc S_IDLE = 3'd0;
    localparam t_upc S_DISP = 3'd1;
    localparam t_upc S_ACHK = 3'd2;
    localparam t_upc S_ACMP = 3'd3;
    localparam t_upc S_PUSH = 3'd4;
    localparam t_upc S_FIN  = 3'd5;
    localparam t_upc S_FCHK = 3'd6;
    localparam t_upc S_FPOP = 3'd7;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // jump to target when the condition holds, otherwise fall through
    localparam t_uword UROM [USTEPS] = '{
        '{OP_LATCH, C_NO_START, S_IDLE},
        '{OP_NONE,  C_FLUSH,    S_FCHK},
        '{OP_NONE,  C_EMPTY,    S_PUSH},
        '{OP_ACMP,  C_FITS,     S_ACHK},
        '{OP_PUSH,  C_ALWAYS,   S_FIN},
        '{OP_FIN,   C_ALWAYS,   S_IDLE},
        '{OP_NONE,  C_EMPTY,    S_FIN},
        '{OP_FPOP,  C_ALWAYS,   S_FCHK}
    };

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic flush;
        logic empty;
        logic fits;
    } t_flags;

endpackage

### src/plts_useq.sv
// microcode sequencer: step counter, control store lookup and conditional jumps
module plts_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  plts_pkg::t_flags i_flags,
    output plts_pkg::t_ctrl  o_ctrl,
    output logic            busy
);

    plts_pkg::t_upc   r_upc;
    plts_pkg::t_upc   n_upc;
    plts_pkg::t_uword word;
    logic             taken;

    assign word = plts_pkg::UROM[r_upc];

    always_comb begin
        case (word.cond)
            plts_pkg::C_ALWAYS:   taken = 1'b1;
            plts_pkg::C_NO_START: taken = !start;
            plts_pkg::C_FLUSH:    taken = i_flags.flush;
            plts_pkg::C_EMPTY:    taken = i_flags.empty;
            plts_pkg::C_FITS:     taken = i_flags.fits;
            default:              taken = 1'b0;
        endcase
        n_upc = taken ? word.target : r_upc + plts_pkg::t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= plts_pkg::S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign busy          = (r_upc != plts_pkg::S_IDLE);
    assign o_ctrl.op     = word.op;
    assign o_ctrl.accept = (word.op == plts_pkg::OP_LATCH) && start;

endmodule

### src/plts_dpath.sv
// datapath: task stack memories, elapsed time, stack count and result staging
module plts_dpath #(
    parameter int STACK_DEPTH = plts_pkg::STACK_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  plts_pkg::t_ctrl           i_ctrl,
    input  logic                      i_opcode,
    input  logic [plts_pkg::ID_W-1:0]  i_task_id,
    input  logic [plts_pkg::MIN_W-1:0] i_start_minute,
    input  logic [plts_pkg::DUR_W-1:0] i_duration,
    output plts_pkg::t_flags          o_flags,
    output logic                      o_valid,
    output logic [plts_pkg::ID_W-1:0]  o_done_id,
    output logic                      o_status,
    output logic                      o_last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [plts_pkg::ID_W-1:0]  mem_id  [STACK_DEPTH];
    logic [plts_pkg::DUR_W-1:0] mem_rem [STACK_DEPTH];

    logic                       r_op;
    logic [plts_pkg::ID_W-1:0]  r_id;
    logic [plts_pkg::DUR_W-1:0] r_dur;
    logic [plts_pkg::MIN_W-1:0] r_elapsed;
    logic [plts_pkg::MIN_W-1:0] r_lem;
    logic [CW-1:0]              r_count;
    logic [plts_pkg::ID_W-1:0]  r_rd_id;
    logic [plts_pkg::DUR_W-1:0] r_rd_rem;

    logic                       r_pend_v;
    logic [plts_pkg::ID_W-1:0]  r_pend_id;
    logic                       r_pend_st;

    logic                       r_o_valid;
    logic [plts_pkg::ID_W-1:0]  r_o_id;
    logic                       r_o_status;
    logic                       r_o_last;

    logic                       empty;
    logic                       full;
    logic                       fits;
    logic [CW-1:0]              top;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       id_we;
    logic                       rem_we;
    logic [plts_pkg::DUR_W-1:0] rem_wdata;
    logic [plts_pkg::MIN_W-1:0] rem_ext;
    logic                       emit;
    logic [plts_pkg::ID_W-1:0]  emit_id;
    logic                       emit_st;
    logic                       fin;

    assign empty   = (r_count == '0);
    assign full    = (r_count == CW'(STACK_DEPTH));
    assign top     = r_count - CW'(1);
    assign rd_addr = empty ? '0 : top[AW-1:0];
    assign rem_ext = {{(plts_pkg::MIN_W - plts_pkg::DUR_W){1'b0}}, r_rd_rem};
    assign fits    = (r_elapsed >= rem_ext);
    assign fin     = (i_ctrl.op == plts_pkg::OP_FIN);

    assign o_flags.flush = r_op;
    assign o_flags.empty = empty;
    assign o_flags.fits  = fits;

    always_comb begin
        id_we     = 1'b0;
        rem_we    = 1'b0;
        wr_addr   = rd_addr;
        rem_wdata = r_dur;
        emit      = 1'b0;
        emit_id   = r_rd_id;
        emit_st   = 1'b0;
        case (i_ctrl.op)
            plts_pkg::OP_ACMP: begin
                if (fits) begin
                    emit = 1'b1;
                end else begin
                    // partly run task keeps what is left
                    rem_we    = 1'b1;
                    rem_wdata = r_rd_rem - r_elapsed[plts_pkg::DUR_W-1:0];
                end
            end
            plts_pkg::OP_PUSH: begin
                if (full) begin
                    emit    = 1'b1;
                    emit_id = r_id;
                    emit_st = 1'b1;
                end else begin
                    id_we   = 1'b1;
                    rem_we  = 1'b1;
                    wr_addr = r_count[AW-1:0];
                end
            end
            plts_pkg::OP_FPOP: begin
                emit = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_id  <= mem_id[rd_addr];
        r_rd_rem <= mem_rem[rd_addr];
        if (id_we) begin
            mem_id[wr_addr] <= r_id;
        end
        if (rem_we) begin
            mem_rem[wr_addr] <= rem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_op  <= i_opcode;
            r_id  <= i_task_id;
            r_dur <= i_duration;
            if (!i_opcode) begin
                r_elapsed <= (i_start_minute >= r_lem) ? i_start_minute - r_lem : '0;
            end
        end else if (i_ctrl.op == plts_pkg::OP_ACMP && fits) begin
            r_elapsed <= r_elapsed - rem_ext;
        end
        r_pend_id  <= emit ? emit_id : r_pend_id;
        r_pend_st  <= emit ? emit_st : r_pend_st;
        r_o_id     <= r_pend_id;
        r_o_status <= r_pend_st;
        r_o_last   <= fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_lem     <= '0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_ctrl.accept && !i_opcode) begin
                r_lem <= i_start_minute;
            end
            if (emit && !emit_st) begin
                r_count <= top;
            end else if (id_we) begin
                r_count <= r_count + CW'(1);
            end
            // a result leaves only once the next one, or the end, is known
            r_o_valid <= r_pend_v && (emit || fin);
            if (emit) begin
                r_pend_v <= 1'b1;
            end else if (fin) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    assign o_valid   = r_o_valid;
    assign o_done_id = r_o_id;
    assign o_status  = r_o_status;
    assign o_last    = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_out_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit || fin) && r_pend_v |=> r_o_valid)
        else $error("staged result not sent");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> !r_pend_v)
        else $error("staged result left after finish");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.op == plts_pkg::OP_FPOP |=> r_count == $past(top))
        else $error("flush pop did not lower the count");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_last |-> $past(fin))
        else $error("last flag without finish step");

endmodule

### src/preemptive_lifo_task_scheduler.sv
// an arrival holds busy while it pops the tasks that finish, and trims a task it cuts short
// a flush holds busy while it drains the stack; results strobe one per cycle at most
// each stack entry visited takes a check step and an act step, due to the registered stack read
// throughput: the next request is taken in the first cycle busy is low
// results cannot be stalled; the final result shows in that first idle cycle; sync active-low reset
// top level of the preemptive lifo task scheduler, reset empties the stack and last event minute
module preemptive_lifo_task_scheduler #(
    parameter int STACK_DEPTH = plts_pkg::STACK_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [plts_pkg::ID_W-1:0]  i_task_id,
    input  logic [plts_pkg::MIN_W-1:0] i_start_minute,
    input  logic [plts_pkg::DUR_W-1:0] i_duration,
    output logic                       o_valid,
    output logic [plts_pkg::ID_W-1:0]  o_done_id,
    output logic                       o_status,
    output logic                       o_last
);

    plts_pkg::t_ctrl  ctrl;
    plts_pkg::t_flags flags;

    plts_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    plts_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_opcode       (i_opcode),
        .i_task_id      (i_task_id),
        .i_start_minute (i_start_minute),
        .i_duration     (i_duration),
        .o_flags        (flags),
        .o_valid        (o_valid),
        .o_done_id      (o_done_id),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule
